/* hw/rtl/lcg_pkg.sv */
package lcg_pkg;

    // Widths of the internal day count and year counter.
    localparam int DAYS_W = 23;
    localparam int YEAR_W = 14;

    // Long count digit weights in days.
    localparam logic [DAYS_W-1:0] W_BAKTUN = 23'd144000;
    localparam logic [DAYS_W-1:0] W_KATUN  = 23'd7200;
    localparam logic [DAYS_W-1:0] W_TUN    = 23'd360;
    localparam logic [DAYS_W-1:0] W_UINAL  = 23'd20;

    // Correlation to the first day of the proleptic Gregorian calendar.
    localparam logic [DAYS_W-1:0] CORRELATION   = 23'd1137143;
    localparam logic [DAYS_W-1:0] DAYS_PER_400Y = 23'd146097;
    localparam logic [DAYS_W-1:0] DAYS_LEAP     = 23'd366;
    localparam logic [DAYS_W-1:0] DAYS_COMMON   = 23'd365;
    localparam logic [YEAR_W-1:0] YEARS_PER_CYCLE = 14'd400;

    localparam logic [3:0] MONTH_JAN = 4'd1;
    localparam logic [3:0] MONTH_FEB = 4'd2;
    localparam logic [3:0] MONTH_APR = 4'd4;
    localparam logic [3:0] MONTH_JUN = 4'd6;
    localparam logic [3:0] MONTH_SEP = 4'd9;
    localparam logic [3:0] MONTH_NOV = 4'd11;
    localparam logic [3:0] MONTH_DEC = 4'd12;

    // Sequencer states.
    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_CORR   = 6'b000010,
        ST_CYC400 = 6'b000100,
        ST_YEAR   = 6'b001000,
        ST_MONTH  = 6'b010000,
        ST_FINISH = 6'b100000
    } state_t;

    // Commands from the sequencer to the year tracker.
    typedef struct packed {
        logic init;
        logic step_year;
        logic step_cycle;
    } yr_ctrl_t;

    // Length of a month in days.
    function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
        logic [4:0] len;
        if (month == MONTH_FEB) begin
            len = leap ? 5'd29 : 5'd28;
        end else if (month == MONTH_APR || month == MONTH_JUN ||
                     month == MONTH_SEP || month == MONTH_NOV) begin
            len = 5'd30;
        end else begin
            len = 5'd31;
        end
        return len;
    endfunction

endpackage

/* hw/rtl/lcg_sub_unit.sv */
module lcg_sub_unit (
    input  logic [lcg_pkg::DAYS_W-1:0] a,
    input  logic [lcg_pkg::DAYS_W-1:0] b,
    output logic [lcg_pkg::DAYS_W-1:0] diff,
    output logic                       ge
);

    // Shared subtractor; the borrow out doubles as the compare result.
    logic [lcg_pkg::DAYS_W:0] wide;

    assign wide = {1'b0, a} - {1'b0, b};
    assign diff = wide[lcg_pkg::DAYS_W-1:0];
    assign ge   = ~wide[lcg_pkg::DAYS_W];

endmodule

/* hw/rtl/lcg_year_track.sv */
module lcg_year_track (
    input  logic                       aclk,
    input  lcg_pkg::yr_ctrl_t          ctrl,
    output logic [lcg_pkg::YEAR_W-1:0] year,
    output logic                       leap
);

    logic [lcg_pkg::YEAR_W-1:0] year_reg;
    logic [lcg_pkg::YEAR_W-1:0] year_next;
    logic [6:0]                 mod100_reg;
    logic [6:0]                 mod100_next;
    logic [8:0]                 mod400_reg;
    logic [8:0]                 mod400_next;

    // Year counter with running remainders by 100 and 400. A 400-year step
    // leaves both remainders unchanged.
    always_comb begin
        year_next   = year_reg;
        mod100_next = mod100_reg;
        mod400_next = mod400_reg;
        priority if (ctrl.init) begin
            year_next   = 14'd1;
            mod100_next = 7'd1;
            mod400_next = 9'd1;
        end else if (ctrl.step_cycle) begin
            year_next = year_reg + lcg_pkg::YEARS_PER_CYCLE;
        end else if (ctrl.step_year) begin
            year_next   = year_reg + 14'd1;
            mod100_next = (mod100_reg == 7'd99) ? 7'd0 : mod100_reg + 7'd1;
            mod400_next = (mod400_reg == 9'd399) ? 9'd0 : mod400_reg + 9'd1;
        end else begin
            year_next   = year_reg;
            mod100_next = mod100_reg;
            mod400_next = mod400_reg;
        end
    end

    always_ff @(posedge aclk) begin
        year_reg   <= year_next;
        mod100_reg <= mod100_next;
        mod400_reg <= mod400_next;
    end

    // Gregorian leap rule on the current year.
    assign leap = (mod400_reg == 9'd0) ||
                  ((mod100_reg != 7'd0) && (year_reg[1:0] == 2'b00));
    assign year = year_reg;

endmodule

/* hw/rtl/long_count_to_gregorian_date.sv */
// Long count to Gregorian date converter.
// An input transfer on the s_ channel carries the five long count digits;
// one result transfer on the m_ channel carries day, month and year.
// The digits are weighted into a day count, the correlation is removed
// (a count at or below it gives 1 January of year 1), and a single shared
// subtract-and-compare unit then peels off whole 400-year cycles, single
// years and months under a small sequencer.
// After the correlation step the sequencer takes one step for each 400-year
// cycle (up to 24), each remaining year (up to 399) and each month passed
// (up to 11). The shared subtractor does one step per cycle.
// s_tready is high only while the sequencer is idle, so one item is
// worked on at a time. The result sits in an output register; a new item
// is accepted while it waits, and its finished result is held back until
// the receiver has taken the previous one.
// Reset (aresetn low at a clock edge) returns the sequencer to idle and
// drops m_tvalid; a pending result is discarded.
module long_count_to_gregorian_date (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // baktun[4:0], katun[9:5], tun[14:10], uinal[19:15], kin[24:20], zero fill
    input  logic [31:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // day_of_month[4:0], month_number[8:5], year_number[21:9], zero fill
    output logic [23:0] m_tdata
);

    localparam int DW = lcg_pkg::DAYS_W;

    lcg_pkg::state_t state_reg;
    lcg_pkg::state_t state_next;

    logic [DW-1:0]  rem_reg;
    logic [DW-1:0]  rem_next;
    logic [3:0]     month_reg;
    logic [3:0]     month_next;
    logic           m_valid_reg;
    logic           m_valid_next;
    logic [4:0]     day_out_reg;
    logic [3:0]     month_out_reg;
    logic [12:0]    year_out_reg;
    logic           load_out;

    logic [4:0]     baktun;
    logic [4:0]     katun;
    logic [4:0]     tun;
    logic [4:0]     uinal;
    logic [4:0]     kin;
    logic [DW-1:0]  count;

    logic [DW-1:0]  sub_b;
    logic [DW-1:0]  sub_diff;
    logic           sub_ge;

    lcg_pkg::yr_ctrl_t          yr_ctrl;
    logic [lcg_pkg::YEAR_W-1:0] year;
    logic                       leap;

    // Unpack the digits and weight them into a day count.
    assign baktun = s_tdata[4:0];
    assign katun  = s_tdata[9:5];
    assign tun    = s_tdata[14:10];
    assign uinal  = s_tdata[19:15];
    assign kin    = s_tdata[24:20];

    assign count = {{(DW-5){1'b0}}, baktun} * lcg_pkg::W_BAKTUN
                 + {{(DW-5){1'b0}}, katun}  * lcg_pkg::W_KATUN
                 + {{(DW-5){1'b0}}, tun}    * lcg_pkg::W_TUN
                 + {{(DW-5){1'b0}}, uinal}  * lcg_pkg::W_UINAL
                 + {{(DW-5){1'b0}}, kin};

    // Operand for the shared subtractor, chosen by the sequencer state.
    always_comb begin
        unique case (state_reg)
            lcg_pkg::ST_CORR:   sub_b = lcg_pkg::CORRELATION;
            lcg_pkg::ST_CYC400: sub_b = lcg_pkg::DAYS_PER_400Y;
            lcg_pkg::ST_YEAR:   sub_b = leap ? lcg_pkg::DAYS_LEAP : lcg_pkg::DAYS_COMMON;
            lcg_pkg::ST_MONTH:  sub_b = {{(DW-5){1'b0}}, lcg_pkg::month_len(month_reg, leap)};
            default:            sub_b = '0;
        endcase
    end

    lcg_sub_unit u_sub (
        .a    (rem_reg),
        .b    (sub_b),
        .diff (sub_diff),
        .ge   (sub_ge)
    );

    lcg_year_track u_year (
        .aclk (aclk),
        .ctrl (yr_ctrl),
        .year (year),
        .leap (leap)
    );

    // Sequencer: one subtraction per cycle until the date is found.
    always_comb begin
        state_next = state_reg;
        rem_next   = rem_reg;
        month_next = month_reg;
        yr_ctrl    = '0;
        load_out   = 1'b0;
        unique case (state_reg)
            lcg_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    rem_next     = count;
                    month_next   = lcg_pkg::MONTH_JAN;
                    yr_ctrl.init = 1'b1;
                    state_next   = lcg_pkg::ST_CORR;
                end
            end
            lcg_pkg::ST_CORR: begin
                rem_next   = sub_ge ? sub_diff : '0;
                state_next = lcg_pkg::ST_CYC400;
            end
            lcg_pkg::ST_CYC400: begin
                if (sub_ge) begin
                    rem_next           = sub_diff;
                    yr_ctrl.step_cycle = 1'b1;
                end else begin
                    state_next = lcg_pkg::ST_YEAR;
                end
            end
            lcg_pkg::ST_YEAR: begin
                if (sub_ge) begin
                    rem_next          = sub_diff;
                    yr_ctrl.step_year = 1'b1;
                end else begin
                    state_next = lcg_pkg::ST_MONTH;
                end
            end
            lcg_pkg::ST_MONTH: begin
                if (sub_ge && (month_reg < lcg_pkg::MONTH_DEC)) begin
                    rem_next   = sub_diff;
                    month_next = month_reg + 4'd1;
                end else begin
                    state_next = lcg_pkg::ST_FINISH;
                end
            end
            lcg_pkg::ST_FINISH: begin
                if (!m_valid_reg || m_tready) begin
                    load_out   = 1'b1;
                    state_next = lcg_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = lcg_pkg::ST_IDLE;
            end
        endcase
    end

    // Output register valid flag.
    always_comb begin
        m_valid_next = m_valid_reg;
        priority if (load_out) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= lcg_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Working registers and result payload.
    always_ff @(posedge aclk) begin
        rem_reg   <= rem_next;
        month_reg <= month_next;
        if (load_out) begin
            day_out_reg   <= rem_reg[4:0] + 5'd1;
            month_out_reg <= month_reg;
            year_out_reg  <= year[12:0];
        end
    end

    assign s_tready = (state_reg == lcg_pkg::ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, year_out_reg, month_out_reg, day_out_reg};

endmodule

/* hw/rtl/lcg_checker.sv */
module lcg_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [31:0] s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);

    // No result is offered right after reset.
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // A stalled result holds its value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // The block is busy right after it takes an item.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tdata[0] == s_tdata[0] |=> !s_tready)
        else $error("second item taken while converting");

    // Month of an offered result lies in 1 to 12 and its day is not zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[8:5] != 4'd0) && (m_tdata[8:5] <= 4'd12) &&
                     (m_tdata[4:0] != 5'd0))
        else $error("month or day out of range");

endmodule

bind long_count_to_gregorian_date lcg_checker u_lcg_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
